>>> hw/rtl/fletcher_style_checksum_32_core_defines.svh
// ----------------------------------------------------------------------------
// fletcher style checksum assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef FLETCHER_STYLE_CHECKSUM_32_CORE_DEFINES_SVH
`define FLETCHER_STYLE_CHECKSUM_32_CORE_DEFINES_SVH

// assertion that is switched off while reset is high
`define FSC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion that also holds while reset is high
`define FSC_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/fsc32_pkg.sv
// ----------------------------------------------------------------------------
// fsc32 package
// command codes, queue entry type and sizes shared by the checksum core
// ----------------------------------------------------------------------------
package fsc32_pkg;

  localparam int WORD_BYTES  = 4;
  localparam int BYTE_BITS   = 8;
  localparam int WORD_BITS   = WORD_BYTES * BYTE_BITS;
  localparam int COUNT_W     = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command field codes
  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_ABSORB   = 2'd1;
  localparam logic [1:0] CMD_FINALIZE = 2'd2;

  // operations that reach the back end
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ABSORB,
    OP_FINALIZE
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [BYTE_BITS-1:0] data_byte;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hw/rtl/fsc32_if.sv
// ----------------------------------------------------------------------------
// fsc32 channel interfaces
// valid/ready channels for command items and checksum items
// ----------------------------------------------------------------------------
interface fsc32_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface fsc32_sum_if;
  logic        valid;
  logic        ready;
  logic [31:0] checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

>>> hw/rtl/fsc32_front.sv
// ----------------------------------------------------------------------------
// fsc32 front end
// accepts command items, decodes them and pushes operations into the queue
// ----------------------------------------------------------------------------
module fsc32_front (
  fsc32_cmd_if.sink            request,
  input  fsc32_pkg::q_status_t q_status,
  output fsc32_pkg::q_push_t   q_push
);

  logic          take;
  logic          keep;
  fsc32_pkg::op_t op;

  assign request.ready = !q_status.full;
  assign take          = request.valid && request.ready;

  always_comb begin
    keep = 1'b1;
    op   = fsc32_pkg::OP_ABSORB;
    unique case (request.command)
      fsc32_pkg::CMD_CLEAR:    op = fsc32_pkg::OP_CLEAR;
      fsc32_pkg::CMD_ABSORB:   op = fsc32_pkg::OP_ABSORB;
      fsc32_pkg::CMD_FINALIZE: op = fsc32_pkg::OP_FINALIZE;
      default:                 keep = 1'b0; // unused code, dropped
    endcase
  end

  assign q_push.push            = take && keep;
  assign q_push.entry.op        = op;
  assign q_push.entry.data_byte = request.data_byte;

endmodule

>>> hw/rtl/fsc32_queue.sv
// ----------------------------------------------------------------------------
// fsc32 operation queue
// small register fifo between the front and back ends
// ----------------------------------------------------------------------------
module fsc32_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  fsc32_pkg::q_push_t    q_push,
  input  logic                  pop,
  output fsc32_pkg::q_entry_t   head,
  output fsc32_pkg::q_status_t  q_status
);

  fsc32_pkg::q_entry_t               slots [fsc32_pkg::QUEUE_DEPTH];
  logic [fsc32_pkg::QPTR_W-1:0]      wr_ptr;
  logic [fsc32_pkg::QPTR_W-1:0]      rd_ptr;
  logic [fsc32_pkg::QCNT_W-1:0]      count;
  logic                              do_push;
  logic                              do_pop;

  assign q_status.full  = (count == fsc32_pkg::QCNT_W'(fsc32_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign do_push        = q_push.push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == fsc32_pkg::QPTR_W'(fsc32_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == fsc32_pkg::QPTR_W'(fsc32_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/fsc32_back.sv
// ----------------------------------------------------------------------------
// fsc32 back end
// runs queued operations on the running sums and holds the result register
// ----------------------------------------------------------------------------
module fsc32_back (
  input  logic                 clk,
  input  logic                 rst,
  input  fsc32_pkg::q_entry_t  head,
  input  logic                 q_empty,
  output logic                 pop,
  fsc32_sum_if.source          result
);

  logic [fsc32_pkg::WORD_BITS-1:0] first_sum;
  logic [fsc32_pkg::WORD_BITS-1:0] second_sum;
  logic [fsc32_pkg::WORD_BITS-1:0] packing_word;
  logic [fsc32_pkg::COUNT_W-1:0]   packed_count;

  logic [fsc32_pkg::WORD_BITS-1:0] first_sum_next;
  logic [fsc32_pkg::WORD_BITS-1:0] second_sum_next;
  logic [fsc32_pkg::WORD_BITS-1:0] packing_word_next;
  logic [fsc32_pkg::COUNT_W-1:0]   packed_count_next;

  logic [fsc32_pkg::WORD_BITS-1:0] digest_first;
  logic [fsc32_pkg::WORD_BITS-1:0] digest_second;
  logic [fsc32_pkg::WORD_BITS-1:0] byte_ext;
  logic [1:0]                      slot;
  logic                            word_full;
  logic                            out_free;
  logic                            emit;

  assign out_free = !result.valid || result.ready;
  // a finalize waits only for the result register
  assign pop  = !q_empty && ((head.op != fsc32_pkg::OP_FINALIZE) || out_free);
  assign emit = pop && (head.op == fsc32_pkg::OP_FINALIZE);

  assign word_full     = (packed_count >= fsc32_pkg::COUNT_W'(fsc32_pkg::WORD_BYTES));
  assign digest_first  = first_sum + packing_word;
  assign digest_second = second_sum + digest_first;
  assign byte_ext      = {{(fsc32_pkg::WORD_BITS - fsc32_pkg::BYTE_BITS){1'b0}}, head.data_byte};
  // free slot counted from the top byte down
  assign slot          = ~packed_count[1:0];

  always_comb begin
    first_sum_next    = first_sum;
    second_sum_next   = second_sum;
    packing_word_next = packing_word;
    packed_count_next = packed_count;
    if (pop) begin
      unique case (head.op) inside
        fsc32_pkg::OP_CLEAR, fsc32_pkg::OP_FINALIZE: begin
          first_sum_next    = '0;
          second_sum_next   = '0;
          packing_word_next = '0;
          packed_count_next = '0;
        end
        fsc32_pkg::OP_ABSORB: begin
          if (word_full) begin
            first_sum_next    = digest_first;
            second_sum_next   = digest_second;
            packing_word_next = byte_ext << (fsc32_pkg::WORD_BITS - fsc32_pkg::BYTE_BITS);
            packed_count_next = fsc32_pkg::COUNT_W'(1);
          end else begin
            packing_word_next = packing_word | (byte_ext << {slot, 3'b000});
            packed_count_next = packed_count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_sum    <= '0;
      second_sum   <= '0;
      packing_word <= '0;
      packed_count <= '0;
      result.valid <= 1'b0;
    end else begin
      first_sum    <= first_sum_next;
      second_sum   <= second_sum_next;
      packing_word <= packing_word_next;
      packed_count <= packed_count_next;
      if (emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // second minus first after the final digest
  always_ff @(posedge clk) begin
    if (emit) begin
      result.checksum <= digest_second - digest_first;
    end
  end

endmodule

>>> hw/rtl/fletcher_style_checksum_32_core.sv
// ----------------------------------------------------------------------------
// fletcher style checksum core
// two 32-bit running sums over a byte stream, result on finalize
// ----------------------------------------------------------------------------
// usage
// - request channel: one item per cycle while the queue is not full, command
//   0 clears, 1 absorbs data_byte, 2 finalizes; code 3 is taken and dropped
// - result channel: one checksum item per finalize, nothing for other items
// - throughput: one item per cycle, set by the back end, which retires one
//   queued operation per cycle with one add pair on the sums, and stalls
//   only at a finalize while the result register holds an item not yet taken
// - a finalize accepted into an empty queue is written into the queue, then
//   the back end digests it into the result register, which sets result.valid
// - the front end decodes items into a four-entry queue; request.ready
//   drops only while the queue is full
// - receiver stall: the result register holds its item; the back end keeps
//   retiring clear and absorb operations and waits only at a finalize,
//   so the waiting finalize and three items behind it fill the queue and
//   request.ready falls
// - reset (synchronous, rst high): sums, packing word, byte count and the
//   queue are cleared and result.valid goes low; no clearing pass
// ----------------------------------------------------------------------------
module fletcher_style_checksum_32_core (
  input  logic       clk,
  input  logic       rst,
  fsc32_cmd_if.sink  request,
  fsc32_sum_if.source result
);

  fsc32_pkg::q_push_t   q_push;    // decoded operation from the front end
  fsc32_pkg::q_status_t q_status;  // queue full and empty
  fsc32_pkg::q_entry_t  head;      // oldest queued operation
  logic                 pop;       // back end retires the head

  // decode and push
  fsc32_front u_front (
    .request  (request),
    .q_status (q_status),
    .q_push   (q_push)
  );

  // decouples the request side from result stalls
  fsc32_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_push   (q_push),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // running sums and result register
  fsc32_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_status.empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

>>> hw/rtl/fsc32_checker.sv
// ----------------------------------------------------------------------------
// fsc32 port checker
// checks the core ports over time, attached by bind
// ----------------------------------------------------------------------------
`include "fletcher_style_checksum_32_core_defines.svh"

module fsc32_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_checksum
);

  `FSC_ASSERT_RST(a_reset_drops_valid, clk, rst |=> !res_valid, "result valid after reset")
  `FSC_ASSERT_RST(a_reset_empties_queue, clk, rst |=> req_ready, "queue not empty after reset")
  `FSC_ASSERT(a_valid_holds, clk, rst, res_valid && !res_ready |=> res_valid, "result dropped")
  `FSC_ASSERT(a_sum_holds, clk, rst, res_valid && !res_ready |=> $stable(res_checksum), "result changed")

endmodule

bind fletcher_style_checksum_32_core fsc32_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (request.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_checksum (result.checksum)
);
